### rtl/lrfs_pkg.sv
// ----------------------------------------------------------------------------
// lrfs_pkg
// Types and constants shared by the longest-remaining-first scheduler modules.
// ----------------------------------------------------------------------------
package lrfs_pkg;

	localparam int unsigned ID_W    = 8;
	localparam int unsigned BURST_W = 16;
	localparam int unsigned COUNT_W = 18;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 18'h3FFFF;

	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_TICK = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;

	typedef struct packed {
		logic [1:0]         kind;
		logic [1:0]         slot;
		logic [ID_W-1:0]    job_id;
		logic [BURST_W-1:0] burst_time;
	} in_t;

	typedef struct packed {
		logic               chosen_valid;
		logic [ID_W-1:0]    chosen_id;
		logic [COUNT_W-1:0] completion_time;
		logic [COUNT_W-1:0] waiting_time;
	} out_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic latch;     // capture the request and clear the scan state
		logic exec;      // perform a load, read or ignored request
		logic scan_step; // compare one table slot against the current best
		logic apply;     // commit the tick and present its result
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic is_tick;
		logic scan_last;
	} stat_t;

endpackage

### rtl/lrfs_ctrl.sv
// ----------------------------------------------------------------------------
// lrfs_ctrl
// Controller state machine: sequences dispatch, slot scan and tick commit.
// ----------------------------------------------------------------------------
module lrfs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  lrfs_pkg::stat_t stat,
	output lrfs_pkg::cmd_t  cmd,
	output logic           busy
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SCAN,
		ST_APPLY
	} state_t;

	state_t state_q;
	logic   busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_DISPATCH;
						busy_q  <= 1'b1;
					end
				end
				ST_DISPATCH: begin
					if (stat.is_tick) begin
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_IDLE;
						busy_q  <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (stat.scan_last) begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.latch     = (state_q == ST_IDLE) && start;
		cmd.exec      = (state_q == ST_DISPATCH) && !stat.is_tick;
		cmd.scan_step = (state_q == ST_SCAN);
		cmd.apply     = (state_q == ST_APPLY);
	end

	assign busy = busy_q;

endmodule

### rtl/lrfs_datapath.sv
// ----------------------------------------------------------------------------
// lrfs_datapath
// Job table, one-slot-per-cycle best-job scan and result register.
// ----------------------------------------------------------------------------
module lrfs_datapath #(
	parameter int unsigned NUM_ENTRIES = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  lrfs_pkg::cmd_t  cmd,
	input  lrfs_pkg::in_t   item,
	output lrfs_pkg::stat_t stat,
	output logic            done,
	output lrfs_pkg::out_t  result
);

	localparam int unsigned IDX_W = $clog2(NUM_ENTRIES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);

	logic [lrfs_pkg::ID_W-1:0]    job_ids_q [NUM_ENTRIES];
	logic [lrfs_pkg::BURST_W-1:0] bursts_q  [NUM_ENTRIES];
	logic [lrfs_pkg::BURST_W-1:0] rem_q     [NUM_ENTRIES];
	logic [lrfs_pkg::COUNT_W-1:0] fc_q      [NUM_ENTRIES];

	lrfs_pkg::in_t                item_q;
	logic [IDX_W-1:0]             scan_idx_q;
	logic                         best_found_q;
	logic [IDX_W-1:0]             best_idx_q;
	logic [lrfs_pkg::BURST_W-1:0] best_rem_q;
	logic [lrfs_pkg::ID_W-1:0]    best_id_q;
	logic                         done_q;
	lrfs_pkg::out_t               result_q;

	logic [31:0]                  slot_ext;
	logic [IDX_W-1:0]             slot_idx;
	logic                         slot_ok;
	logic [IDX_W-1:0]             rd_idx;
	logic [lrfs_pkg::ID_W-1:0]    rd_id;
	logic [lrfs_pkg::BURST_W-1:0] rd_burst;
	logic [lrfs_pkg::BURST_W-1:0] rd_rem;
	logic [lrfs_pkg::COUNT_W-1:0] rd_fc;
	logic [lrfs_pkg::COUNT_W-1:0] rd_burst_ext;
	logic                         better;

	assign slot_ext = 32'(item_q.slot);
	assign slot_idx = slot_ext[IDX_W-1:0];
	assign slot_ok  = (slot_ext < NUM_ENTRIES);

	// Single read port shared by the scan and the slot read
	assign rd_idx       = cmd.scan_step ? scan_idx_q : slot_idx;
	assign rd_id        = job_ids_q[rd_idx];
	assign rd_burst     = bursts_q[rd_idx];
	assign rd_rem       = rem_q[rd_idx];
	assign rd_fc        = fc_q[rd_idx];
	assign rd_burst_ext = lrfs_pkg::COUNT_W'(rd_burst);

	// Ties go to the lower id, then to the lower slot (strict compare)
	assign better = (rd_rem != '0) &&
		(!best_found_q || (rd_rem > best_rem_q) ||
		 ((rd_rem == best_rem_q) && (rd_id < best_id_q)));

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			item_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q   <= '0;
			best_found_q <= 1'b0;
			best_idx_q   <= '0;
			best_rem_q   <= '0;
			best_id_q    <= '0;
		end else if (cmd.latch) begin
			scan_idx_q   <= '0;
			best_found_q <= 1'b0;
		end else if (cmd.scan_step) begin
			scan_idx_q <= scan_idx_q + 1'b1;
			if (better) begin
				best_found_q <= 1'b1;
				best_idx_q   <= scan_idx_q;
				best_rem_q   <= rd_rem;
				best_id_q    <= rd_id;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				job_ids_q[i] <= '0;
				bursts_q[i]  <= '0;
				rem_q[i]     <= '0;
				fc_q[i]      <= '0;
			end
		end else begin
			if (cmd.exec && (item_q.kind == lrfs_pkg::KIND_LOAD) && slot_ok) begin
				job_ids_q[slot_idx] <= item_q.job_id;
				bursts_q[slot_idx]  <= item_q.burst_time;
				rem_q[slot_idx]     <= item_q.burst_time;
				fc_q[slot_idx]      <= '0;
			end
			if (cmd.apply && best_found_q) begin
				for (int i = 0; i < NUM_ENTRIES; i++) begin
					if ((rem_q[i] != '0) && (fc_q[i] < lrfs_pkg::COUNT_MAX)) begin
						fc_q[i] <= fc_q[i] + 1'b1;
					end
				end
				rem_q[best_idx_q] <= rem_q[best_idx_q] - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.exec || cmd.apply;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec || cmd.apply) begin
			result_q <= '0;
			if (cmd.apply && best_found_q) begin
				result_q.chosen_valid <= 1'b1;
				result_q.chosen_id    <= best_id_q;
			end
			if (cmd.exec && (item_q.kind == lrfs_pkg::KIND_READ) && slot_ok) begin
				result_q.completion_time <= rd_fc;
				// clamp an early read to zero waiting time
				result_q.waiting_time    <= (rd_fc >= rd_burst_ext) ?
					(rd_fc - rd_burst_ext) : '0;
			end
		end
	end

	assign stat.is_tick   = (item_q.kind == lrfs_pkg::KIND_TICK);
	assign stat.scan_last = (scan_idx_q == LAST_IDX);
	assign done           = done_q;
	assign result         = result_q;

endmodule

### rtl/longest_remaining_first_scheduler_top.sv
// ----------------------------------------------------------------------------
// longest_remaining_first_scheduler_top
// Longest-remaining-time-first scheduler over a small table of job slots.
// ----------------------------------------------------------------------------
// A request is taken on item at a rising edge with start high and busy low.
// A load writes one slot (id, burst, remaining = burst, completion cleared),
// a tick serves the unfinished job with the most remaining time (ties to the
// lower id, then the lower slot), a read returns completion and waiting time
// of one slot. Every request gives exactly one result on result, shown for a
// single cycle with done high; the receiver cannot stall, so results are
// never held.
// done follows the dispatch state for a load or read, and for a tick it follows
// the dispatch state, the scan that visits one table slot per cycle through the
// single table read port, and the apply state. busy stays high from the
// accepting edge until the cycle done is shown; the next request can be taken
// at the edge that ends that cycle, so a new request is not taken before the
// last one has shown its result.
// Reset clears the whole table (all slots empty) and the controller at once;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
module longest_remaining_first_scheduler_top #(
	parameter int unsigned NUM_ENTRIES = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  lrfs_pkg::in_t  item,
	output logic           done,
	output lrfs_pkg::out_t result
);

	lrfs_pkg::cmd_t  cmd;
	lrfs_pkg::stat_t stat;

	lrfs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	lrfs_datapath #(
		.NUM_ENTRIES (NUM_ENTRIES)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.stat   (stat),
		.done   (done),
		.result (result)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a request in work");

	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("busy still high while the result is shown");

	a_tick_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.chosen_valid) |->
			(result.completion_time == '0) && (result.waiting_time == '0))
		else $error("tick result carries read fields");

endmodule
